// ===== design/cdbm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdbm_pkg
// Types, codes and reset values shared by the call depth and budget monitor.
// ---------------------------------------------------------------------------
package cdbm_pkg;

   localparam int NUM_KINDS_DEF = 3;

   localparam int DEPTH_W = 16;
   localparam int BYTES_W = 32;
   localparam int VALUE_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DEPTH_W-1:0] TOTAL_LIMIT_RST = 16'd256;
   localparam logic [DEPTH_W-1:0] FUNC_LIMIT_RST = 16'd128;
   localparam logic [DEPTH_W-1:0] DELEG_LIMIT_RST = 16'd128;
   localparam logic [BYTES_W-1:0] TEMP_BUDGET_RST = 32'd16 * 32'd1024 * 32'd1024;
   localparam logic [BYTES_W-1:0] STACK_RESERVE_RST = 32'd64 * 32'd1024;

   localparam logic [1:0] KIND_FUNCTION = 2'd0;
   localparam logic [1:0] KIND_DELEGATION = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TOTAL_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FUNC_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DELEG_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_BUDGET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STACK_RESERVE = 3'd4;

   localparam logic [4:0] STAT_TOTAL_DEPTH = 5'd0;
   localparam logic [4:0] STAT_TEMP_BYTES = 5'd1;
   localparam logic [4:0] STAT_PEAK_TOTAL = 5'd2;
   localparam logic [4:0] STAT_PEAK_TEMP = 5'd3;
   localparam logic [4:0] STAT_TOTAL_LIMIT = 5'd4;
   localparam logic [4:0] STAT_TEMP_BUDGET = 5'd5;
   localparam logic [4:0] STAT_STACK_FREE = 5'd6;
   localparam logic [4:0] STAT_STACK_RESERVE = 5'd7;
   localparam logic [4:0] STAT_KIND_DEPTH0 = 5'd8;
   localparam logic [4:0] STAT_KIND_DEPTH1 = 5'd9;
   localparam logic [4:0] STAT_KIND_DEPTH2 = 5'd10;
   localparam logic [4:0] STAT_LOWEST_FREE = 5'd11;
   localparam logic [4:0] STAT_FUNC_LIMIT = 5'd12;
   localparam logic [4:0] STAT_DELEG_LIMIT = 5'd13;
   localparam logic [4:0] STAT_KIND_PEAK0 = 5'd14;
   localparam logic [4:0] STAT_KIND_PEAK1 = 5'd15;
   localparam logic [4:0] STAT_KIND_PEAK2 = 5'd16;

   typedef enum logic [2:0] {
      CMD_ENTER   = 3'd0,
      CMD_LEAVE   = 3'd1,
      CMD_RESERVE = 3'd2,
      CMD_RELEASE = 3'd3,
      CMD_STAT    = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_FUNC   = 3'd1,
      ST_DELEG  = 3'd2,
      ST_TOTAL  = 3'd3,
      ST_STACK  = 3'd4,
      ST_BUDGET = 3'd5
   } status_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] total_depth_limit;
      logic [DEPTH_W-1:0] function_depth_limit;
      logic [DEPTH_W-1:0] delegation_depth_limit;
      logic [BYTES_W-1:0] temporary_budget;
      logic [BYTES_W-1:0] stack_reserve;
   } cfg_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [1:0]         frame_kind;
      logic [BYTES_W-1:0] byte_count;
      logic [BYTES_W-1:0] stack_free_now;
      logic [4:0]         stat_select;
   } req_item_type;

endpackage

// ===== design/call_depth_and_budget_monitor_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// call_depth_and_budget_monitor_unit
// Frame depth, stack reserve and temporary byte budget monitor.
// ---------------------------------------------------------------------------
// usage:
//   req_ stream carries enter, leave, reserve, release and stat requests;
//   rsp_ stream returns one status and statistic value per request, in order.
//   csr_ write port sets the depth limits, byte budget and stack reserve;
//   write it only while no request is in flight.
//   a request is captured in the input register; when it leaves that
//   register it is checked and applied to the counters, and its response
//   lands in the result register, which drives rsp_tvalid.
//   throughput is one request per cycle while rsp_tready is high; the
//   counter update is a single compare-and-increment pass, so a request
//   sees the state left by the one just ahead of it.
//   when rsp_tready is low the response holds, the input register takes one
//   more request, and then req_tready drops until the result drains.
//   reset clears both stages, zeroes the depth and byte counters and peaks,
//   sets the lowest free stack mark to all ones and loads the default limits.
// ---------------------------------------------------------------------------
module call_depth_and_budget_monitor_unit #(
   parameter int NUM_KINDS = cdbm_pkg::NUM_KINDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [71:0]                      req_tdata,  // byte_count, stack_free_now, stat_select
   input  logic [4:0]                       req_tuser,  // cmd, frame_kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // stat_value
   output logic [2:0]                       rsp_tuser,  // status
   input  logic                             csr_we,
   input  logic [cdbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cdbm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cdbm_pkg::*;

   cfg_type             cfg;
   req_item_type        in_item_ff, in_item_in;
   logic                in_valid_ff, in_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   status_type          core_status;
   logic [VALUE_W-1:0]  core_value;
   logic                advance;
   logic                req_accept;

   cdbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cdbm_core #(
      .NUM_KINDS (NUM_KINDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .advance    (advance),
      .item       (in_item_ff),
      .status     (core_status),
      .stat_value (core_value)
   );

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_item_in.cmd = cmd_type'(req_tuser[2:0]);
      in_item_in.frame_kind = req_tuser[4:3];
      in_item_in.byte_count = req_tdata[31:0];
      in_item_in.stack_free_now = req_tdata[63:32];
      in_item_in.stat_select = req_tdata[68:64];
      in_valid_in = req_accept || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         rsp_status_ff <= core_status;
         rsp_value_ff <= core_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_value_ff;
   assign rsp_tuser = rsp_status_ff;

   // a stalled input stage only happens behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stage stalled without a held response");

   // an accepted request always occupies the input stage next cycle
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted request was not captured");

   // a processed request always produces a response next cycle
   a_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no response");

   // only enter and reserve can report a failure
   a_status_src: assert property (@(posedge clock) disable iff (reset)
      (advance && core_status != ST_OK) |->
         (in_item_ff.cmd == CMD_ENTER || in_item_ff.cmd == CMD_RESERVE))
      else $error("failure status from a command that cannot fail");

endmodule

// ===== design/cdbm_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdbm_csr
// Limit and budget registers, written through a plain write port.
// ---------------------------------------------------------------------------
module cdbm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [cdbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cdbm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output cdbm_pkg::cfg_type                  cfg
);
   import cdbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TOTAL_LIMIT: cfg_in.total_depth_limit = csr_wdata[DEPTH_W-1:0];
            REG_FUNC_LIMIT: cfg_in.function_depth_limit = csr_wdata[DEPTH_W-1:0];
            REG_DELEG_LIMIT: cfg_in.delegation_depth_limit = csr_wdata[DEPTH_W-1:0];
            REG_TEMP_BUDGET: cfg_in.temporary_budget = csr_wdata[BYTES_W-1:0];
            REG_STACK_RESERVE: cfg_in.stack_reserve = csr_wdata[BYTES_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_depth_limit <= TOTAL_LIMIT_RST;
         cfg_ff.function_depth_limit <= FUNC_LIMIT_RST;
         cfg_ff.delegation_depth_limit <= DELEG_LIMIT_RST;
         cfg_ff.temporary_budget <= TEMP_BUDGET_RST;
         cfg_ff.stack_reserve <= STACK_RESERVE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/cdbm_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cdbm_core
// Depth and budget counters with the check-and-update logic for one request.
// ---------------------------------------------------------------------------
module cdbm_core #(
   parameter int NUM_KINDS = cdbm_pkg::NUM_KINDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cdbm_pkg::cfg_type                 cfg,
   input  logic                              advance,
   input  cdbm_pkg::req_item_type            item,
   output cdbm_pkg::status_type              status,
   output logic [cdbm_pkg::VALUE_W-1:0]      stat_value
);
   import cdbm_pkg::*;

   logic [DEPTH_W-1:0] total_depth_ff, total_depth_in;
   logic [DEPTH_W-1:0] peak_total_ff, peak_total_in;
   logic [BYTES_W-1:0] lowest_free_ff, lowest_free_in;
   logic [BYTES_W-1:0] temp_bytes_ff, temp_bytes_in;
   logic [BYTES_W-1:0] peak_temp_ff, peak_temp_in;
   logic [DEPTH_W-1:0] kind_depth_ff [NUM_KINDS];
   logic [DEPTH_W-1:0] kind_depth_in [NUM_KINDS];
   logic [DEPTH_W-1:0] kind_peak_ff [NUM_KINDS];
   logic [DEPTH_W-1:0] kind_peak_in [NUM_KINDS];

   logic               kind_known;
   logic [DEPTH_W-1:0] cur_kind_depth;
   logic [DEPTH_W-1:0] kind_depth_inc;
   logic [BYTES_W:0]   reserve_sum;

   // selected kind counter
   always_comb begin
      kind_known = 1'b0;
      cur_kind_depth = '0;
      for (int k = 0; k < NUM_KINDS; k++) begin
         if (int'(item.frame_kind) == k) begin
            kind_known = 1'b1;
            cur_kind_depth = kind_depth_ff[k];
         end
      end
      kind_depth_inc = (cur_kind_depth == {DEPTH_W{1'b1}}) ? cur_kind_depth
                                                           : cur_kind_depth + 1'b1;
      reserve_sum = {1'b0, temp_bytes_ff} + {1'b0, item.byte_count};
   end

   always_comb begin
      total_depth_in = total_depth_ff;
      peak_total_in = peak_total_ff;
      lowest_free_in = lowest_free_ff;
      temp_bytes_in = temp_bytes_ff;
      peak_temp_in = peak_temp_ff;
      kind_depth_in = kind_depth_ff;
      kind_peak_in = kind_peak_ff;
      status = ST_OK;
      case (item.cmd)
         CMD_ENTER: begin
            if (kind_known && item.frame_kind == KIND_FUNCTION &&
                cur_kind_depth >= cfg.function_depth_limit) begin
               status = ST_FUNC;
            end else if (kind_known && item.frame_kind == KIND_DELEGATION &&
                         cur_kind_depth >= cfg.delegation_depth_limit) begin
               status = ST_DELEG;
            end else if (total_depth_ff >= cfg.total_depth_limit) begin
               status = ST_TOTAL;
            end else begin
               if (item.stack_free_now < lowest_free_ff) begin
                  lowest_free_in = item.stack_free_now;
               end
               if (item.stack_free_now < cfg.stack_reserve) begin
                  status = ST_STACK;
               end else begin
                  total_depth_in = total_depth_ff + 1'b1;
                  if (total_depth_in > peak_total_ff) begin
                     peak_total_in = total_depth_in;
                  end
                  for (int k = 0; k < NUM_KINDS; k++) begin
                     if (int'(item.frame_kind) == k) begin
                        kind_depth_in[k] = kind_depth_inc;
                        if (kind_depth_inc > kind_peak_ff[k]) begin
                           kind_peak_in[k] = kind_depth_inc;
                        end
                     end
                  end
               end
            end
         end
         CMD_LEAVE: begin
            if (total_depth_ff != '0) begin
               total_depth_in = total_depth_ff - 1'b1;
            end
            for (int k = 0; k < NUM_KINDS; k++) begin
               if (int'(item.frame_kind) == k && kind_depth_ff[k] != '0) begin
                  kind_depth_in[k] = kind_depth_ff[k] - 1'b1;
               end
            end
         end
         CMD_RESERVE: begin
            if (reserve_sum > {1'b0, cfg.temporary_budget}) begin
               status = ST_BUDGET;
            end else begin
               temp_bytes_in = reserve_sum[BYTES_W-1:0];
               if (reserve_sum[BYTES_W-1:0] > peak_temp_ff) begin
                  peak_temp_in = reserve_sum[BYTES_W-1:0];
               end
            end
         end
         CMD_RELEASE: begin
            temp_bytes_in = (item.byte_count > temp_bytes_ff) ? '0
                                                              : temp_bytes_ff - item.byte_count;
         end
         default: status = ST_OK;
      endcase
   end

   // statistic read
   always_comb begin
      stat_value = '0;
      if (item.cmd == CMD_STAT) begin
         case (item.stat_select)
            STAT_TOTAL_DEPTH: stat_value = VALUE_W'(total_depth_ff);
            STAT_TEMP_BYTES: stat_value = temp_bytes_ff;
            STAT_PEAK_TOTAL: stat_value = VALUE_W'(peak_total_ff);
            STAT_PEAK_TEMP: stat_value = peak_temp_ff;
            STAT_TOTAL_LIMIT: stat_value = VALUE_W'(cfg.total_depth_limit);
            STAT_TEMP_BUDGET: stat_value = cfg.temporary_budget;
            STAT_STACK_FREE: stat_value = item.stack_free_now;
            STAT_STACK_RESERVE: stat_value = cfg.stack_reserve;
            STAT_KIND_DEPTH0, STAT_KIND_DEPTH1, STAT_KIND_DEPTH2: begin
               for (int k = 0; k < NUM_KINDS; k++) begin
                  if (int'(item.stat_select) == int'(STAT_KIND_DEPTH0) + k) begin
                     stat_value = VALUE_W'(kind_depth_ff[k]);
                  end
               end
            end
            STAT_LOWEST_FREE: stat_value = lowest_free_ff;
            STAT_FUNC_LIMIT: stat_value = VALUE_W'(cfg.function_depth_limit);
            STAT_DELEG_LIMIT: stat_value = VALUE_W'(cfg.delegation_depth_limit);
            STAT_KIND_PEAK0, STAT_KIND_PEAK1, STAT_KIND_PEAK2: begin
               for (int k = 0; k < NUM_KINDS; k++) begin
                  if (int'(item.stat_select) == int'(STAT_KIND_PEAK0) + k) begin
                     stat_value = VALUE_W'(kind_peak_ff[k]);
                  end
               end
            end
            default: stat_value = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_depth_ff <= '0;
         peak_total_ff <= '0;
         lowest_free_ff <= '1;
         temp_bytes_ff <= '0;
         peak_temp_ff <= '0;
         for (int k = 0; k < NUM_KINDS; k++) begin
            kind_depth_ff[k] <= '0;
            kind_peak_ff[k] <= '0;
         end
      end else if (advance) begin
         total_depth_ff <= total_depth_in;
         peak_total_ff <= peak_total_in;
         lowest_free_ff <= lowest_free_in;
         temp_bytes_ff <= temp_bytes_in;
         peak_temp_ff <= peak_temp_in;
         kind_depth_ff <= kind_depth_in;
         kind_peak_ff <= kind_peak_in;
      end
   end

endmodule
